// ----- rtl/lpd_pkg.sv -----
// Package: shared constants and types of the local peak detector.
package lpd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam longint unsigned RECORD_MAX = 64'd65536;
  localparam int INDEX_WIDTH = 16;
  localparam int DIST_WIDTH = 16;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic {
    REG_MIN_HEIGHT   = 1'b0,
    REG_MIN_DISTANCE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

// ----- rtl/lpd_cfg.sv -----
// Configuration registers behind the APB-style port.
module lpd_cfg #(
  parameter int SAMPLE_WIDTH = lpd_pkg::SAMPLE_WIDTH,
  parameter int PDATA_W = 32,
  parameter int PADDR_W = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [PADDR_W-1:0]             paddr,
  input  logic [PDATA_W-1:0]             pwdata,
  output logic [PDATA_W-1:0]             prdata,
  output logic signed [SAMPLE_WIDTH-1:0] min_height,
  output logic [lpd_pkg::DIST_WIDTH-1:0] min_distance
);

  lpd_pkg::reg_idx_t sel;
  logic              wr;

  assign sel = lpd_pkg::reg_idx_t'(paddr[PADDR_W-1]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_height   <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      min_distance <= '0;
    end else if (wr) begin
      case (sel)
        lpd_pkg::REG_MIN_HEIGHT:   min_height <= pwdata[SAMPLE_WIDTH-1:0];
        lpd_pkg::REG_MIN_DISTANCE: min_distance <= pwdata[lpd_pkg::DIST_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      lpd_pkg::REG_MIN_HEIGHT:   prdata = PDATA_W'(min_height);
      lpd_pkg::REG_MIN_DISTANCE: prdata = PDATA_W'(min_distance);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- rtl/lpd_core.sv -----
// Peak decision logic and per-record state.
module lpd_core #(
  parameter int SAMPLE_WIDTH = lpd_pkg::SAMPLE_WIDTH,
  parameter longint unsigned RECORD_MAX = lpd_pkg::RECORD_MAX,
  parameter int RES_W = SAMPLE_WIDTH + lpd_pkg::INDEX_WIDTH + 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_fire,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           last_in_record,
  input  logic signed [SAMPLE_WIDTH-1:0] min_height,
  input  logic [lpd_pkg::DIST_WIDTH-1:0] min_distance,
  output lpd_pkg::push_t                 push,
  output logic [RES_W-1:0]               res0,
  output logic [RES_W-1:0]               res1
);

  localparam int POS_W = $clog2(RECORD_MAX);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(RECORD_MAX - 64'd1);
  localparam int DW = (POS_W > lpd_pkg::DIST_WIDTH) ? POS_W : lpd_pkg::DIST_WIDTH;
  localparam int IW = lpd_pkg::INDEX_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] older_sample, older_sample_next;
  logic signed [SAMPLE_WIDTH-1:0] newer_sample, newer_sample_next;
  logic [POS_W-1:0]               sample_position, sample_position_next;
  logic [POS_W-1:0]               last_peak_position, last_peak_position_next;
  logic                           peak_seen, peak_seen_next;
  logic                           overflow_seen, overflow_seen_next;
  logic [1:0]                     held, held_next;

  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] lastp_mid;
  logic             ovf;
  logic             found;
  logic             acc_mid;
  logic             seen_mid;
  logic             acc_last;
  logic [RES_W-1:0] res_mid;
  logic [RES_W-1:0] res_end;

  always_comb begin
    if (held == 2'd0) begin
      idx = '0;
    end else if (sample_position < POS_MAX) begin
      idx = sample_position + POS_W'(1);
    end else begin
      idx = POS_MAX;
    end
    ovf = overflow_seen | ((held != 2'd0) & (sample_position == POS_MAX));

    found = (held != 2'd0) & (newer_sample > sample) &
            (~held[1] | (older_sample < newer_sample));
    acc_mid = found & (newer_sample >= min_height) &
              ~(peak_seen & (DW'(sample_position - last_peak_position) < DW'(min_distance)));
    seen_mid  = peak_seen | acc_mid;
    lastp_mid = acc_mid ? sample_position : last_peak_position;

    acc_last = (held != 2'd0) & (sample > newer_sample) & (sample >= min_height) &
               ~(seen_mid & (DW'(idx - lastp_mid) < DW'(min_distance)));

    // fields from bit 0: is_peak, index, value, end_of_record, overflow
    res_mid = {ovf, 1'b0, newer_sample, IW'(sample_position), 1'b1};
    res_end = {ovf, 1'b1,
               acc_last ? sample : {SAMPLE_WIDTH{1'b0}},
               acc_last ? IW'(idx) : {IW{1'b0}},
               acc_last};

    push.push0 = in_fire & (acc_mid | last_in_record);
    push.push1 = in_fire & acc_mid & last_in_record;
    res0 = acc_mid ? res_mid : res_end;
    res1 = res_end;

    older_sample_next       = older_sample;
    newer_sample_next       = newer_sample;
    sample_position_next    = sample_position;
    last_peak_position_next = last_peak_position;
    peak_seen_next          = peak_seen;
    overflow_seen_next      = overflow_seen;
    held_next               = held;
    if (in_fire) begin
      if (last_in_record) begin
        older_sample_next       = '0;
        newer_sample_next       = '0;
        sample_position_next    = '0;
        last_peak_position_next = '0;
        peak_seen_next          = 1'b0;
        overflow_seen_next      = 1'b0;
        held_next               = 2'd0;
      end else begin
        older_sample_next       = newer_sample;
        newer_sample_next       = sample;
        sample_position_next    = idx;
        last_peak_position_next = lastp_mid;
        peak_seen_next          = seen_mid;
        overflow_seen_next      = ovf;
        held_next               = held[1] ? held : held + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample       <= '0;
      newer_sample       <= '0;
      sample_position    <= '0;
      last_peak_position <= '0;
      peak_seen          <= 1'b0;
      overflow_seen      <= 1'b0;
      held               <= 2'd0;
    end else begin
      older_sample       <= older_sample_next;
      newer_sample       <= newer_sample_next;
      sample_position    <= sample_position_next;
      last_peak_position <= last_peak_position_next;
      peak_seen          <= peak_seen_next;
      overflow_seen      <= overflow_seen_next;
      held               <= held_next;
    end
  end

endmodule

// ----- rtl/lpd_fifo.sv -----
// Result queue: up to two writes per cycle, one read.
module lpd_fifo #(
  parameter int RES_W = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  lpd_pkg::push_t   push,
  input  logic [RES_W-1:0] res0,
  input  logic [RES_W-1:0] res1,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RES_W-1:0] out_res
);

  localparam int DEPTH = lpd_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [RES_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       n_push;
  logic             pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign in_ready  = (count <= CNT_W'(DEPTH - 2));
  assign n_push    = {1'b0, push.push0} + {1'b0, push.push1};
  assign count_next = count + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= res0;
    end
    if (push.push1) begin
      mem[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

// ----- rtl/local_peak_detector_top.sv -----
// Top level of the local peak detector.
// A result is written into the result queue when its sample is accepted and is presented from the queue head.
// Throughput: one sample per cycle while s_tready is high; a record's final sample may queue two results.
// s_tready drops while the result queue holds more than two results.
// Synchronous reset clears record state and the queue, and restores
// min_height to the most negative value and min_distance to zero.
module local_peak_detector_top #(
  parameter int SAMPLE_WIDTH = lpd_pkg::SAMPLE_WIDTH,
  parameter longint unsigned RECORD_MAX = lpd_pkg::RECORD_MAX,
  localparam int IN_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int IW      = lpd_pkg::INDEX_WIDTH,
  localparam int OUT_W   = ((IW + SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int PDATA_W = (SAMPLE_WIDTH > 32) ? 64 : 32,
  localparam int PADDR_W = (SAMPLE_WIDTH > 32) ? 4 : 3
) (
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata: sample
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,
  input  logic                   s_tlast,
  // m_tdata: peak_index, peak_value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,
  // m_tuser: is_peak, index_overflow
  output logic [1:0]             m_tuser,
  output logic                   m_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  localparam int RES_W   = SAMPLE_WIDTH + IW + 3;

  logic signed [SAMPLE_WIDTH-1:0] min_height;
  logic [lpd_pkg::DIST_WIDTH-1:0] min_distance;
  lpd_pkg::push_t                 push;
  logic [RES_W-1:0]               res0, res1, out_res;

  assign pready = 1'b1;

  lpd_cfg #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .PDATA_W(PDATA_W),
    .PADDR_W(PADDR_W)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .min_height(min_height),
    .min_distance(min_distance)
  );

  lpd_core #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .RECORD_MAX(RECORD_MAX),
    .RES_W(RES_W)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .in_fire(s_tvalid & s_tready),
    .sample(s_tdata[SAMPLE_WIDTH-1:0]),
    .last_in_record(s_tlast),
    .min_height(min_height),
    .min_distance(min_distance),
    .push(push),
    .res0(res0),
    .res1(res1)
  );

  lpd_fifo #(
    .RES_W(RES_W)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .res0(res0),
    .res1(res1),
    .in_ready(s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res(out_res)
  );

  assign m_tdata = OUT_W'(out_res[IW+SAMPLE_WIDTH:1]);
  assign m_tuser = {out_res[RES_W-1], out_res[0]};
  assign m_tlast = out_res[RES_W-2];

endmodule

// ----- rtl/lpd_checker.sv -----
// Port-level assertions for the local peak detector, bound to the top level.
module lpd_checker #(
  parameter int SAMPLE_WIDTH = lpd_pkg::SAMPLE_WIDTH,
  localparam int OUT_W = ((lpd_pkg::INDEX_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_W-1:0]       m_tdata,
  input logic [1:0]             m_tuser,
  input logic                   m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled result changed");

  a_no_peak_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("non-peak result carries data");

  a_mid_is_peak: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[0])
    else $error("result without end of record is not a peak");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("queue not empty after reset");

endmodule

bind local_peak_detector_top lpd_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lpd_checker (.*);
